[rtl/ffclp_pkg.sv]
`timescale 1ns / 1ps

package ffclp_pkg;

  localparam int MaxLine = 128;

  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharFive  = 8'h35;

  localparam logic [2:0] OffComma = 3'd0;
  localparam logic [2:0] OffDot   = 3'd4;

  localparam int PfxTemp = 0;
  localparam int PfxAnt  = 1;
  localparam int PfxOk   = 2;
  localparam int PfxName = 3;

  typedef enum logic [2:0] {
    KindUnknown = 3'd0,
    KindTemp    = 3'd1,
    KindAnt     = 3'd2,
    KindOk      = 3'd3,
    KindName    = 3'd4,
    KindOld     = 3'd5
  } kind_e;

  // one classified byte, handed from front to back
  typedef struct packed {
    logic [3:0] kill;
    logic       chk;
    logic [1:0] grp;
    logic [2:0] off;
    logic       at30;
    logic       is_comma;
    logic       is_dot;
    logic       is_digit;
    logic       is_five;
    logic [3:0] digit;
    logic       last;
    logic [1:0] chan;
    logic       len11;
    logic       len31;
    logic       len32;
  } op_t;

  typedef struct packed {
    kind_e           kind;
    logic            ok;
    logic [1:0]      chan;
    logic [3:0][9:0] ints;
    logic [3:0][6:0] decs;
  } res_t;

  function automatic logic [2:0] pfx_len(input logic [1:0] idx);
    logic [2:0] r;
    case (idx)
      2'd0:    r = 3'd4;
      2'd1:    r = 3'd3;
      2'd2:    r = 3'd2;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pfx_char(input logic [1:0] idx, input logic [2:0] j);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      2'd0: begin
        case (j)
          3'd0:    r = 8'h74;
          3'd1:    r = 8'h65;
          3'd2:    r = 8'h6d;
          3'd3:    r = 8'h70;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (j)
          3'd0:    r = 8'h61;
          3'd1:    r = 8'h6e;
          3'd2:    r = 8'h74;
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (j)
          3'd0:    r = 8'h6f;
          3'd1:    r = 8'h6b;
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (j)
          3'd0:    r = 8'h6e;
          3'd1:    r = 8'h61;
          3'd2:    r = 8'h6d;
          3'd3:    r = 8'h65;
          3'd4:    r = 8'h3a;
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/ffclp_front.sv]
`timescale 1ns / 1ps

module ffclp_front #(
  parameter int MAX_LINE = ffclp_pkg::MaxLine
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             ready_i,
  input  logic [7:0]       byte_i,
  input  logic [1:0]       chan_i,
  input  logic             last_i,
  output ffclp_pkg::op_t   op_o
);

  localparam int PosW = $clog2(MAX_LINE);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW:0]   len;
  logic [4:0]      q5;
  logic [1:0]      grp;
  logic [4:0]      off5;

  assign len = {1'b0, pos_q} + (PosW+1)'(1);
  assign q5  = pos_q[4:0] - 5'd4;

  always_comb begin
    if (q5 >= 5'd21) begin
      grp = 2'd3;
    end else if (q5 >= 5'd14) begin
      grp = 2'd2;
    end else if (q5 >= 5'd7) begin
      grp = 2'd1;
    end else begin
      grp = 2'd0;
    end
    off5 = q5 - {grp, 3'b000} + {3'b000, grp};
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      op_o.kill[i] =
        ((pos_q < PosW'(ffclp_pkg::pfx_len(2'(i)))) &&
         (byte_i != ffclp_pkg::pfx_char(2'(i), pos_q[2:0]))) ||
        (last_i && (len < (PosW+1)'(ffclp_pkg::pfx_len(2'(i)))));
    end
    op_o.chk      = (pos_q >= PosW'(4)) && ({1'b0, pos_q} <= (PosW+1)'(31));
    op_o.grp      = grp;
    op_o.off      = off5[2:0];
    op_o.at30     = (pos_q == PosW'(30));
    op_o.is_comma = (byte_i == ffclp_pkg::CharComma);
    op_o.is_dot   = (byte_i == ffclp_pkg::CharDot);
    op_o.is_digit = (byte_i >= ffclp_pkg::CharZero) && (byte_i <= ffclp_pkg::CharNine);
    op_o.is_five  = (byte_i == ffclp_pkg::CharFive);
    op_o.digit    = byte_i[3:0];
    op_o.last     = last_i;
    op_o.chan     = chan_i;
    op_o.len11    = (len >= (PosW+1)'(11));
    op_o.len31    = (len >= (PosW+1)'(31));
    op_o.len32    = (len >= (PosW+1)'(32));
  end

  always_comb begin
    pos_d = pos_q;
    if (valid_i && ready_i) begin
      if (last_i) begin
        pos_d = '0;
      end else if (pos_q < PosW'(MAX_LINE - 1)) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/ffclp_fifo.sv]
`timescale 1ns / 1ps

module ffclp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ffclp_pkg::op_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ffclp_pkg::op_t data_o
);

  ffclp_pkg::op_t mem_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/ffclp_back.sv]
`timescale 1ns / 1ps

module ffclp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  ffclp_pkg::op_t   op_i,
  output logic             op_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ffclp_pkg::res_t  res_o
);

  logic [3:0]       flags_q, flags_d;
  logic             err_q, err_d;
  logic             ant5_q, ant5_d;
  logic [3:0][9:0]  int_q, int_d;
  logic [3:0][6:0]  dec_q, dec_d;
  logic             out_valid_q;
  ffclp_pkg::res_t  res_q, res_d;
  logic             slot_free, fire;
  logic             temp_on, ant_on, act, bad;
  logic             show0, show123;

  assign slot_free   = !out_valid_q || res_ready_i;
  assign op_ready_o  = !op_i.last || slot_free;
  assign fire        = op_valid_i && op_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    flags_d = flags_q & ~op_i.kill;
    temp_on = flags_d[ffclp_pkg::PfxTemp];
    ant_on  = flags_d[ffclp_pkg::PfxAnt];
    ant5_d  = ant5_q | (ant_on && op_i.chk && op_i.at30 && op_i.is_five);
    act     = op_i.chk && (temp_on ? (op_i.grp == 2'd0) : ant_on);
    if (op_i.off == ffclp_pkg::OffComma) begin
      bad = !op_i.is_comma;
    end else if (op_i.off == ffclp_pkg::OffDot) begin
      bad = temp_on && !op_i.is_dot;
    end else begin
      bad = !op_i.is_digit;
    end
    err_d = err_q | (act && bad);
    int_d = int_q;
    dec_d = dec_q;
    for (int k = 0; k < 4; k++) begin
      if (act && op_i.is_digit && (op_i.grp == 2'(k))) begin
        if ((op_i.off != ffclp_pkg::OffComma) && (op_i.off < ffclp_pkg::OffDot)) begin
          int_d[k] = {int_q[k][6:0], 3'b000} + {int_q[k][8:0], 1'b0} + {6'd0, op_i.digit};
        end else if (op_i.off > ffclp_pkg::OffDot) begin
          dec_d[k] = {dec_q[k][3:0], 3'b000} + {dec_q[k][5:0], 1'b0} + {3'd0, op_i.digit};
        end
      end
    end
  end

  always_comb begin
    res_d.kind = ffclp_pkg::KindUnknown;
    res_d.ok   = 1'b0;
    res_d.chan = op_i.chan;
    if (flags_d[ffclp_pkg::PfxTemp]) begin
      res_d.kind = ffclp_pkg::KindTemp;
      res_d.ok   = !err_d && op_i.len11;
    end else if (flags_d[ffclp_pkg::PfxAnt]) begin
      if (!ant5_d || !op_i.len31) begin
        res_d.kind = ffclp_pkg::KindOld;
      end else begin
        res_d.kind = ffclp_pkg::KindAnt;
        res_d.ok   = !err_d && op_i.len32;
      end
    end else if (flags_d[ffclp_pkg::PfxOk]) begin
      res_d.kind = ffclp_pkg::KindOk;
      res_d.ok   = 1'b1;
    end else if (flags_d[ffclp_pkg::PfxName]) begin
      res_d.kind = ffclp_pkg::KindName;
      res_d.ok   = 1'b1;
    end
    show0   = res_d.ok && ((res_d.kind == ffclp_pkg::KindTemp) ||
                           (res_d.kind == ffclp_pkg::KindAnt));
    show123 = res_d.ok && (res_d.kind == ffclp_pkg::KindAnt);
    for (int k = 0; k < 4; k++) begin
      if ((k == 0) ? show0 : show123) begin
        res_d.ints[k] = int_d[k];
        res_d.decs[k] = dec_d[k];
      end else begin
        res_d.ints[k] = '0;
        res_d.decs[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= 4'hf;
      err_q       <= 1'b0;
      ant5_q      <= 1'b0;
      int_q       <= '0;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        if (op_i.last) begin
          flags_q <= 4'hf;
          err_q   <= 1'b0;
          ant5_q  <= 1'b0;
          int_q   <= '0;
          dec_q   <= '0;
        end else begin
          flags_q <= flags_d;
          err_q   <= err_d;
          ant5_q  <= ant5_d;
          int_q   <= int_d;
          dec_q   <= dec_d;
        end
      end
      if (fire && op_i.last) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && op_i.last) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/fixed_field_command_line_parser.sv]
`timescale 1ns / 1ps

// channel   dir  tdata                            tuser                     tlast
// s_axis    in   rx_byte[7:0]                     line_channel[1:0]         line_end
// m_axis    out  field0..3 int/dec, 68 of 72 bits kind[2:0] ok[3] chan[5:4] -
//
// one byte accepted per cycle while the queue is not full; the record is registered as the last byte leaves the queue
// the front holds the byte position, a two-entry queue feeds the back accumulators
// reset puts the block straight into the start-of-line state, no clearing pass
// a record waiting on m_axis stalls only the back on the next last byte; the queue
// keeps taking bytes until it is full

module fixed_field_command_line_parser #(
  parameter int MAX_LINE = ffclp_pkg::MaxLine
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // line_channel[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // field0_int, field0_dec, field1_int, field1_dec, field2_int, field2_dec,
  // field3_int, field3_dec, zero pad
  output logic [71:0] m_axis_tdata,
  // command_kind[2:0], parse_ok, source_channel[1:0]
  output logic [5:0]  m_axis_tuser
);

  ffclp_pkg::op_t  front_op, q_op;
  ffclp_pkg::res_t res;
  logic            q_full, q_valid, q_pop;

  assign s_axis_tready = !q_full;

  ffclp_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_i(s_axis_tready),
    .byte_i (s_axis_tdata),
    .chan_i (s_axis_tuser),
    .last_i (s_axis_tlast),
    .op_o   (front_op)
  );

  ffclp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid),
    .data_i (front_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_op)
  );

  ffclp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_op),
    .op_ready_o (q_pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tuser = {res.chan, res.ok, res.kind};
  assign m_axis_tdata = {4'd0,
                         res.decs[3], res.ints[3], res.decs[2], res.ints[2],
                         res.decs[1], res.ints[1], res.decs[0], res.ints[0]};

  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_pop) |-> (q_op.last && m_axis_tvalid && !m_axis_tready))
    else $error("back stalled without a pending record");

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with an empty queue");

  a_rec_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(q_valid && q_pop && q_op.last))
    else $error("record without a last byte");

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.ok) |->
      (res.kind != ffclp_pkg::KindUnknown && res.kind != ffclp_pkg::KindOld))
    else $error("parse_ok on unknown or old antenna");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int ByteTarget = 1600;
  localparam int NumDir = 23;

  typedef struct {
    string            txt;
    logic [1:0]       ch;
    bit               typed;
    ffclp_pkg::kind_e kind;
    bit               ok;
    int               i0;
    int               d0;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;

  // line decoder state
  int         pos;
  logic [3:0] cand;
  bit         fmt_err;
  bit         new_ant;
  logic [9:0] int_acc [4];
  logic [6:0] dec_acc [4];

  ffclp_pkg::res_t pending_records[$];
  logic [7:0]      line_buf[$];
  int              errors = 0;
  int              bytes_sent = 0;
  int              lines_sent = 0;
  int              records_checked = 0;
  int              kind_seen [6];
  int              stall_left = 0;
  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;

  // typed rows carry the expected kind, ok and value 0; the rest are predicted
  dir_row_t dir_rows [NumDir] = '{
    '{"ok", 2'd0, 1'b1, ffclp_pkg::KindOk, 1'b1, 0, 0},
    '{"okay then", 2'd1, 1'b1, ffclp_pkg::KindOk, 1'b1, 0, 0},
    '{"name:probe", 2'd2, 1'b1, ffclp_pkg::KindName, 1'b1, 0, 0},
    '{"NAME:probe", 2'd3, 1'b1, ffclp_pkg::KindUnknown, 1'b0, 0, 0},
    '{"o", 2'd0, 1'b1, ffclp_pkg::KindUnknown, 1'b0, 0, 0},
    '{"tem", 2'd1, 1'b1, ffclp_pkg::KindUnknown, 1'b0, 0, 0},
    '{"temp", 2'd2, 1'b1, ffclp_pkg::KindTemp, 1'b0, 0, 0},
    '{"temp,999.99", 2'd3, 1'b1, ffclp_pkg::KindTemp, 1'b1, 999, 99},
    '{"temp,000.00", 2'd0, 1'b1, ffclp_pkg::KindTemp, 1'b1, 0, 0},
    '{"temp,123.45 C", 2'd1, 1'b1, ffclp_pkg::KindTemp, 1'b1, 123, 45},
    '{"temp,12a.45", 2'd2, 1'b1, ffclp_pkg::KindTemp, 1'b0, 0, 0},
    '{"temp;123.45", 2'd3, 1'b1, ffclp_pkg::KindTemp, 1'b0, 0, 0},
    '{"temp,123,45", 2'd0, 1'b1, ffclp_pkg::KindTemp, 1'b0, 0, 0},
    '{"temp,123.4", 2'd1, 1'b1, ffclp_pkg::KindTemp, 1'b0, 0, 0},
    '{"ant", 2'd2, 1'b1, ffclp_pkg::KindOld, 1'b0, 0, 0},
    '{"antx,100.00,200.00", 2'd3, 1'b1, ffclp_pkg::KindOld, 1'b0, 0, 0},
    '{"antx,999.99,000.00,123.45,545.49", 2'd0, 1'b1, ffclp_pkg::KindOld, 1'b0, 0, 0},
    '{"antx,999.99,000.00,123.45,555.5", 2'd1, 1'b1, ffclp_pkg::KindAnt, 1'b0, 0, 0},
    '{"antx,999.99,000.00,123.45,555.59", 2'd2, 1'b0, ffclp_pkg::KindUnknown, 1'b0, 0, 0},
    '{"ant:,000.00,999.99,999.99,000.59 tail", 2'd3, 1'b0, ffclp_pkg::KindUnknown,
      1'b0, 0, 0},
    '{"antx,999x99,000.00,123.45,555.59", 2'd0, 1'b0, ffclp_pkg::KindUnknown, 1'b0, 0, 0},
    '{"antx,9a9.99,000.00,123.45,555.59", 2'd1, 1'b1, ffclp_pkg::KindAnt, 1'b0, 0, 0},
    '{"antx;999.99,000.00,123.45,555.59", 2'd2, 1'b1, ffclp_pkg::KindAnt, 1'b0, 0, 0}
  };

  fixed_field_command_line_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic string prefix_text(input int idx);
    case (idx)
      ffclp_pkg::PfxTemp: return "temp";
      ffclp_pkg::PfxAnt:  return "ant";
      ffclp_pkg::PfxOk:   return "ok";
      default:            return "name:";
    endcase
  endfunction

  function automatic void restart_line();
    pos = 0;
    cand = 4'hf;
    fmt_err = 1'b0;
    new_ant = 1'b0;
    for (int k = 0; k < 4; k++) begin
      int_acc[k] = '0;
      dec_acc[k] = '0;
    end
  endfunction

  function automatic bit decode_reply_byte(input logic [7:0] c, input logic [1:0] ch,
                                           input logic eol, output ffclp_pkg::res_t rec);
    int    p;
    int    len;
    int    k;
    int    off;
    int    nvals;
    bit    temp_on;
    bit    ant_on;
    string pfx;
    rec = '0;
    p = pos;
    for (int i = 0; i < 4; i++) begin
      pfx = prefix_text(i);
      if (p < pfx.len() && c != 8'(pfx[p])) cand[i] = 1'b0;
    end
    if (p >= 4 && p <= 31) begin
      k = (p - 4) / 7;
      off = (p - 4) % 7;
      temp_on = cand[ffclp_pkg::PfxTemp];
      ant_on = cand[ffclp_pkg::PfxAnt];
      if (ant_on && p == 30 && c == ffclp_pkg::CharFive) new_ant = 1'b1;
      // a temp line has one value group only
      if ((temp_on && k == 0) || (!temp_on && ant_on)) begin
        if (off == ffclp_pkg::OffComma) begin
          if (c != ffclp_pkg::CharComma) fmt_err = 1'b1;
        end else if (off == ffclp_pkg::OffDot) begin
          if (temp_on && c != ffclp_pkg::CharDot) fmt_err = 1'b1;
        end else if (c < ffclp_pkg::CharZero || c > ffclp_pkg::CharNine) begin
          fmt_err = 1'b1;
        end else if (off <= 3) begin
          int_acc[k] = 10'(int_acc[k] * 10 + (c - ffclp_pkg::CharZero));
        end else begin
          dec_acc[k] = 7'(dec_acc[k] * 10 + (c - ffclp_pkg::CharZero));
        end
      end
    end
    if (!eol) begin
      if (pos < ffclp_pkg::MaxLine - 1) pos++;
      return 1'b0;
    end
    len = p + 1;
    for (int i = 0; i < 4; i++) begin
      pfx = prefix_text(i);
      if (len < pfx.len()) cand[i] = 1'b0;
    end
    nvals = 0;
    rec.chan = ch;
    if (cand[ffclp_pkg::PfxTemp]) begin
      rec.kind = ffclp_pkg::KindTemp;
      rec.ok = !fmt_err && len >= 11;
      nvals = 1;
    end else if (cand[ffclp_pkg::PfxAnt]) begin
      if (!new_ant || len < 31) begin
        rec.kind = ffclp_pkg::KindOld;
      end else begin
        rec.kind = ffclp_pkg::KindAnt;
        rec.ok = !fmt_err && len >= 32;
        nvals = 4;
      end
    end else if (cand[ffclp_pkg::PfxOk]) begin
      rec.kind = ffclp_pkg::KindOk;
      rec.ok = 1'b1;
    end else if (cand[ffclp_pkg::PfxName]) begin
      rec.kind = ffclp_pkg::KindName;
      rec.ok = 1'b1;
    end else begin
      rec.kind = ffclp_pkg::KindUnknown;
    end
    if (rec.ok) begin
      for (int j = 0; j < nvals; j++) begin
        rec.ints[j] = int_acc[j];
        rec.decs[j] = dec_acc[j];
      end
    end
    restart_line();
    return 1'b1;
  endfunction

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
  endfunction

  // comma, three integer digits, dot, two hundredths digits
  function automatic void add_value();
    line_buf.push_back(ffclp_pkg::CharComma);
    repeat (3) line_buf.push_back(ffclp_pkg::CharZero + 8'($urandom_range(0, 9)));
    line_buf.push_back(ffclp_pkg::CharDot);
    repeat (2) line_buf.push_back(ffclp_pkg::CharZero + 8'($urandom_range(0, 9)));
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic send_line(input logic [1:0] ch, input bit mixed, input bit typed,
                           input ffclp_pkg::res_t typed_rec);
    ffclp_pkg::res_t rec;
    int              gap;
    logic [1:0]      cur_ch;
    logic            eol;
    for (int i = 0; i < line_buf.size(); i++) begin
      gap = idle_draw(tx_calm);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      cur_ch = (mixed && $urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : ch;
      eol = (i == line_buf.size() - 1);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= line_buf[i];
      s_axis_tuser <= cur_ch;
      s_axis_tlast <= eol;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      if (decode_reply_byte(line_buf[i], cur_ch, eol, rec)) begin
        pending_records.push_back(typed ? typed_rec : rec);
      end
      bytes_sent++;
      @(negedge clk_i);
    end
    lines_sent++;
  endtask

  // result side: per-record stall, sometimes long runs with none
  initial begin
    forever begin
      @(negedge clk_i);
      if (!rst_ni || stall_left > 0) begin
        m_axis_tready <= 1'b0;
        if (rst_ni) stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : record_check
    ffclp_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none, got kind %0d", $time,
                 m_axis_tuser[2:0]);
        errors++;
      end else begin
        want = pending_records.pop_front();
        compare_field("command_kind", want.kind, m_axis_tuser[2:0]);
        compare_field("parse_ok", want.ok, m_axis_tuser[3]);
        compare_field("source_channel", want.chan, m_axis_tuser[5:4]);
        for (int k = 0; k < 4; k++) begin
          compare_field($sformatf("field%0d_int", k), want.ints[k],
                        m_axis_tdata[17*k +: 10]);
          compare_field($sformatf("field%0d_dec", k), want.decs[k],
                        m_axis_tdata[17*k+10 +: 7]);
        end
        compare_field("tdata pad", 0, m_axis_tdata[71:68]);
        kind_seen[int'(want.kind)]++;
        records_checked++;
      end
      stall_left = idle_draw(rx_calm);
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    ffclp_pkg::res_t typed_rec;
    int              mode;
    int              n;
    logic [1:0]      ch;
    bit              mixed;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    restart_line();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      line_buf.delete();
      add_text(dir_rows[r].txt);
      typed_rec = '0;
      typed_rec.kind = dir_rows[r].kind;
      typed_rec.ok = dir_rows[r].ok;
      typed_rec.chan = dir_rows[r].ch;
      typed_rec.ints[0] = 10'(dir_rows[r].i0);
      typed_rec.decs[0] = 7'(dir_rows[r].d0);
      send_line(dir_rows[r].ch, 1'b0, dir_rows[r].typed, typed_rec);
    end

    typed_rec = '0;
    while (bytes_sent < ByteTarget) begin
      line_buf.delete();
      mode = $urandom_range(0, 99);
      if (mode < 30 || (mode >= 95 && mode[0])) begin
        add_text("temp");
        add_value();
      end else if (mode < 60 || mode >= 95) begin
        add_text("ant");
        line_buf.push_back(8'($urandom_range(0, 255)));
        repeat (4) add_value();
        // mostly new antennas
        if ($urandom_range(0, 9) != 0) line_buf[30] = ffclp_pkg::CharFive;
      end else if (mode < 66) begin
        add_text("ok");
      end else if (mode < 72) begin
        add_text("name:");
      end else begin
        n = $urandom_range(1, 40);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (mode < 72 || mode >= 95) begin
        n = (mode >= 95) ? $urandom_range(100, 140) - line_buf.size()
                         : $urandom_range(0, 4);
        repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 4) == 0) begin
          line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(1, line_buf.size());
          while (line_buf.size() > n) void'(line_buf.pop_back());
        end
      end
      ch = 2'($urandom_range(0, 3));
      mixed = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
      send_line(ch, mixed, 1'b0, typed_rec);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d lines of %0d bytes sent, %0d records checked", lines_sent, bytes_sent,
             records_checked);
    $display("by kind: unknown %0d, temp %0d, antenna %0d, keepalive %0d, name %0d, old %0d",
             kind_seen[ffclp_pkg::KindUnknown], kind_seen[ffclp_pkg::KindTemp],
             kind_seen[ffclp_pkg::KindAnt], kind_seen[ffclp_pkg::KindOk],
             kind_seen[ffclp_pkg::KindName], kind_seen[ffclp_pkg::KindOld]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ffclp_pkg.sv
rtl/ffclp_front.sv
rtl/ffclp_fifo.sv
rtl/ffclp_back.sv
rtl/fixed_field_command_line_parser.sv
tb/tb.sv
